### design/evi_pkg.sv
// Shared types, constants and fixed-point helpers for the eased vector interpolator.
package evi_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] EASE_LINEAR   = 3'd0;
  localparam logic [2:0] EASE_SINE     = 3'd1;
  localparam logic [2:0] EASE_COSINE   = 3'd2;
  localparam logic [2:0] EASE_SQUARE   = 3'd3;
  localparam logic [2:0] EASE_SMOOTH   = 3'd4;
  localparam logic [2:0] EASE_SMOOTHER = 3'd5;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [31:0]        time_step;
    logic [2:0]         ease_mode;
    logic               cancel;
  } req_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               finished;
  } rsp_word_t;

  // Q16 product, rounded half up
  function automatic logic [31:0] mul_q16(input logic [23:0] a, input logic [23:0] b);
    logic [47:0] p;
    p = 48'(a) * 48'(b) + 48'd32768;
    return p[47:16];
  endfunction

  // sin(x) for x in Q30 by Taylor series to x^15, result Q1.16
  function automatic logic [16:0] sine_q16(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) sum = '0;
    e = ($unsigned(sum) + 64'd8192) >> 14;
    if (e > 64'(ONE_Q16)) e = 64'(ONE_Q16);
    return e[16:0];
  endfunction

endpackage

### design/evi_if.sv
// Handshake channels of the eased vector interpolator.
interface evi_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface evi_req_if;
  logic              valid;
  logic              ready;
  evi_pkg::req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface evi_rsp_if;
  logic              valid;
  logic              ready;
  evi_pkg::rsp_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/evi_div.sv
// Serial restoring divider: t = elapsed * 2^16 / duration, one quotient bit a cycle.
module evi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [16:0] quot,
  output logic        done
);

  logic [32:0] rem;
  logic [4:0]  cnt;
  logic [33:0] diff;
  logic        take;
  logic [32:0] rem_next;

  assign diff     = {1'b0, rem} - {2'b00, den};
  assign take     = !diff[33];
  assign rem_next = take ? diff[32:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // elapsed <= duration, so the first step yields the integer bit
        rem  <= {1'b0, num};
        cnt  <= 5'd17;
        quot <= '0;
      end else if (cnt != 5'd0) begin
        quot <= {quot[15:0], take};
        rem  <= {rem_next[31:0], 1'b0};
        cnt  <= cnt - 5'd1;
        done <= (cnt == 5'd1);
      end
    end
  end

endmodule

### design/evi_ease.sv
// Easing curves: four-stage pipeline with a registered sine table read.
module evi_ease #(
  parameter int DEPTH = evi_pkg::SINE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] t,
  input  logic [2:0]  mode,
  output logic [16:0] eased,
  output logic        done
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 1);

  logic [16:0] sine_rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [63:0] X = (64'(i) * evi_pkg::HALF_PI_Q30) / DEPTH;
    assign sine_rom[i] = evi_pkg::sine_q16(X);
  end

  logic [3:0]  vld;
  logic [31:0] idx_prod;
  logic [IW-1:0] idx;

  logic [16:0]   t1, t2_1;
  logic [2:0]    mode1;
  logic [IW-1:0] addr1;

  logic [16:0] t2_2, rd2, t3_2, tl2;
  logic [17:0] sm2;
  logic [19:0] p2;
  logic [2:0]  mode2;
  logic signed [22:0] p_raw;

  logic [16:0] t2_3, rd3, tl3;
  logic [17:0] sm3;
  logic [19:0] st3;
  logic [2:0]  mode3;

  logic [31:0] sq_w, sm_w, st_w;

  assign idx_prod = 32'(t) * 32'(DEPTH) + 32'd32768;
  assign idx      = idx_prod[16 +: IW];

  assign p_raw = 23'sd6 * $signed({6'd0, t2_1}) - 23'sd15 * $signed({6'd0, t1}) + 23'sd655360;
  assign sq_w  = evi_pkg::mul_q16({7'd0, t}, {7'd0, t});
  assign sm_w  = evi_pkg::mul_q16({7'd0, t2_1}, 24'd196608 - {6'd0, t1, 1'b0});
  assign st_w  = evi_pkg::mul_q16({7'd0, t3_2}, {4'd0, p2});

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[2:0], start};
  end

  always_ff @(posedge clk) begin
    // stage 1: square and table phase
    t1    <= t;
    mode1 <= mode;
    t2_1  <= sq_w[16:0];
    addr1 <= (mode == evi_pkg::EASE_COSINE) ? IW'(DEPTH) - idx : idx;
    // stage 2: table read, cube, smoothstep, smootherstep polynomial
    rd2   <= (addr1 >= IW'(DEPTH)) ? evi_pkg::ONE_Q16 : sine_rom[addr1[AW-1:0]];
    t3_2  <= 17'(evi_pkg::mul_q16({7'd0, t2_1}, {7'd0, t1}));
    sm2   <= 18'(sm_w);
    p2    <= p_raw[22] ? 20'd0 : p_raw[19:0];
    t2_2  <= t2_1;
    tl2   <= t1;
    mode2 <= mode1;
    // stage 3: smootherstep product
    st3   <= st_w[19:0];
    sm3   <= sm2;
    rd3   <= rd2;
    t2_3  <= t2_2;
    tl3   <= tl2;
    mode3 <= mode2;
    // stage 4: select and clamp
    unique case (mode3)
      evi_pkg::EASE_SINE:     eased <= rd3;
      evi_pkg::EASE_COSINE:   eased <= evi_pkg::ONE_Q16 - rd3;
      evi_pkg::EASE_SQUARE:   eased <= (t2_3 > evi_pkg::ONE_Q16) ? evi_pkg::ONE_Q16 : t2_3;
      evi_pkg::EASE_SMOOTH:
        eased <= (sm3 > 18'(evi_pkg::ONE_Q16)) ? evi_pkg::ONE_Q16 : sm3[16:0];
      evi_pkg::EASE_SMOOTHER:
        eased <= (st3 > 20'(evi_pkg::ONE_Q16)) ? evi_pkg::ONE_Q16 : st3[16:0];
      default:                eased <= tl3;
    endcase
  end

  assign done = vld[3];

endmodule

### design/evi_lane.sv
// One axis lane: start + (target - start) * eased, rounded half away from zero.
module evi_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] s,
  input  logic signed [31:0] g,
  input  logic [16:0]        e,
  output logic signed [31:0] result,
  output logic               done
);

  logic [2:0]         vld;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic signed [31:0] s1, s2;
  logic [16:0]        e1;
  logic [50:0]        mag;
  logic [34:0]        qmag;
  logic [31:0]        q;

  assign mag  = prod[50] ? 51'(-prod) : 51'(prod);
  assign qmag = 35'((mag + 51'd32768) >> 16);
  assign q    = prod[50] ? 32'(-qmag) : qmag[31:0];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[1:0], start};
  end

  always_ff @(posedge clk) begin
    diff   <= 33'(g) - 33'(s);
    s1     <= s;
    e1     <= e;
    prod   <= 51'(diff) * $signed({1'b0, e1});
    s2     <= s1;
    result <= s2 + $signed(q);
  end

  assign done = vld[2];

endmodule

### design/eased_vector_interpolator_unit.sv
// Top level of the eased vector interpolator: run control, divider, easing and three lanes.
//
//   channel | dir | handshake         | word
//   cfg     | in  | cfg.valid/ready   | lerp_duration, 32 bit unsigned Q16.16
//   req     | in  | req.valid/ready   | start, target, time_step, ease_mode, cancel
//   rsp     | out | rsp.valid/ready   | out_x, out_y, out_z, finished
//
// A normal word passes the 17-step serial divider, then 4 easing stages,
// 3 lane stages and the handoffs between them.
// A cancel or end-of-run word goes from idle straight to the output state.
// Reset clears the run, elapsed count and duration (to 1.0 s) at once.
// One word is in flight; a finished result waits in the output register while the
// next word is accepted, and the block stalls only if a second result is ready first.
module eased_vector_interpolator_unit #(
  parameter int SINE_TABLE_DEPTH = evi_pkg::SINE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  evi_cfg_if.sink      cfg,
  evi_req_if.sink      req,
  evi_rsp_if.source    rsp
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_EASE, S_LERP, S_OUT} state_t;

  state_t             state;
  logic [31:0]        lerp_duration;
  logic               running;
  logic [31:0]        elapsed;
  logic signed [31:0] held_start [3];
  logic signed [31:0] target [3];
  logic [2:0]         held_mode;
  logic [16:0]        t_val;
  logic               div_start, ease_start, lane_start;
  evi_pkg::rsp_word_t res;

  logic [32:0]        sum;
  logic [31:0]        elapsed_next;
  logic [16:0]        div_q;
  logic               div_done;
  logic [16:0]        eased;
  logic               ease_done;
  logic [2:0]         lane_done;
  logic signed [31:0] lane_out [3];

  assign sum          = {1'b0, elapsed} + {1'b0, req.data.time_step};
  assign elapsed_next = (sum >= {1'b0, lerp_duration}) ? lerp_duration : sum[31:0];

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lerp_duration <= 32'd65536;
      running       <= 1'b0;
      elapsed       <= '0;
      held_mode     <= evi_pkg::EASE_LINEAR;
      held_start    <= '{default: '0};
      div_start     <= 1'b0;
      ease_start    <= 1'b0;
      lane_start    <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      ease_start <= 1'b0;
      lane_start <= 1'b0;
      if (rsp.ready && state != S_OUT) rsp.valid <= 1'b0;
      if (cfg.valid && cfg.ready) lerp_duration <= cfg.data;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.data.cancel || elapsed == lerp_duration) begin
              running <= 1'b0;
              elapsed <= '0;
              res     <= '{out_x: '0, out_y: '0, out_z: '0, finished: 1'b1};
              state   <= S_OUT;
            end else begin
              if (!running) begin
                held_start[0] <= req.data.start_x;
                held_start[1] <= req.data.start_y;
                held_start[2] <= req.data.start_z;
                held_mode     <= req.data.ease_mode;
              end
              running   <= 1'b1;
              target[0] <= req.data.target_x;
              target[1] <= req.data.target_y;
              target[2] <= req.data.target_z;
              elapsed   <= elapsed_next;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            // duration cut to zero mid-run: treat as fully elapsed
            t_val      <= (lerp_duration == '0) ? evi_pkg::ONE_Q16 : div_q;
            ease_start <= 1'b1;
            state      <= S_EASE;
          end
        end
        S_EASE: begin
          if (ease_done) begin
            lane_start <= 1'b1;
            state      <= S_LERP;
          end
        end
        S_LERP: begin
          if (lane_done[0]) begin
            res   <= '{out_x: lane_out[0], out_y: lane_out[1], out_z: lane_out[2],
                       finished: 1'b0};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  evi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (elapsed),
    .den   (lerp_duration),
    .quot  (div_q),
    .done  (div_done)
  );

  evi_ease #(.DEPTH(SINE_TABLE_DEPTH)) u_ease (
    .clk   (clk),
    .rst   (rst),
    .start (ease_start),
    .t     (t_val),
    .mode  (held_mode),
    .eased (eased),
    .done  (ease_done)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    evi_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (lane_start),
      .s      (held_start[a]),
      .g      (target[a]),
      .e      (eased),
      .result (lane_out[a]),
      .done   (lane_done[a])
    );
  end

  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.finished |->
      rsp.data.out_x == 0 && rsp.data.out_y == 0 && rsp.data.out_z == 0)
    else $error("finished word carries nonzero coordinates");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide state");

  a_ease_in_state: assert property (@(posedge clk) disable iff (rst)
    ease_done |-> state == S_EASE)
    else $error("easing done outside easing state");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    $countones(lane_done) == 0 || $countones(lane_done) == 3)
    else $error("lanes out of step");

endmodule
